// ===== design/bpc_pkg.sv =====
// Shared types and constants of the barometric compensation core.
`default_nettype none

package bpc_pkg;

   // dividend and divisor magnitude widths of the pressure divider
   localparam int NUM_W      = 64;
   localparam int DEN_W      = 31;
   localparam int DIV_STAGES = NUM_W;

   // calibration register indexes
   localparam logic [1:0] CSR_CAL_TEMP   = 2'd0;
   localparam logic [1:0] CSR_CAL_P_LOW  = 2'd1;
   localparam logic [1:0] CSR_CAL_P_MID  = 2'd2;
   localparam logic [1:0] CSR_CAL_P_HIGH = 2'd3;

   // unpacked calibration words; t1 and p1 unsigned, the rest signed
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } cal_type;

   // result fields that ride along the pressure path
   typedef struct packed {
      logic [15:0] temp_centi;
      logic [31:0] fine_temp;
      logic        invalid;
   } side_type;

endpackage

`default_nettype wire

// ===== design/bpc_temp.sv =====
// Temperature compensation pipeline: five stages from raw reading to fine term.
`default_nettype none

module bpc_temp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire bpc_pkg::cal_type   cal,
   input  wire logic               in_valid,
   input  wire logic [19:0]        raw_temperature,
   input  wire logic [19:0]        raw_pressure,
   output logic                    out_valid,
   output logic signed [31:0]      out_v1,
   output logic [19:0]             out_raw_pressure,
   output bpc_pkg::side_type       out_side
);

   localparam int STAGES = 5;

   logic [STAGES-1:0]  vld_ff;
   logic [19:0]        rp_ff [STAGES];

   logic signed [15:0] t2;
   logic signed [15:0] t3;

   logic signed [17:0] a1_in, a1_ff;
   logic signed [16:0] b1_in, b1_ff;
   logic signed [33:0] m1_in, m1_ff;
   logic signed [33:0] bb2_in, bb2_ff;
   logic signed [22:0] v1t3_ff;
   logic signed [21:0] bbs;
   logic signed [37:0] m3_in, m3_ff;
   logic signed [31:0] tf4_in, tf4_ff;
   logic signed [34:0] t5;
   logic signed [34:0] sum35;
   logic signed [26:0] tcs;
   logic [15:0]        tc_in;
   logic signed [31:0] v1_in, v1_ff;
   bpc_pkg::side_type  side_ff;

   assign t2 = cal.t2;
   assign t3 = cal.t3;

   assign a1_in  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
   assign b1_in  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
   assign m1_in  = 34'(a1_ff) * 34'(t2);
   assign bb2_in = 34'(b1_ff) * 34'(b1_ff);
   assign bbs    = bb2_ff[33:12];
   assign m3_in  = 38'(bbs) * 38'(t3);
   assign tf4_in = {{9{v1t3_ff[22]}}, v1t3_ff} + {{8{m3_ff[37]}}, m3_ff[37:14]};

   // (tf * 5 + 128) >>> 8, then clamp to 16 bits
   assign t5    = {{3{tf4_ff[31]}}, tf4_ff};
   assign sum35 = (t5 <<< 2) + t5 + 35'sd128;
   assign tcs   = sum35[34:8];
   assign v1_in = tf4_ff - 32'sd128000;

   always_comb begin
      if (tcs > 27'sd32767) begin
         tc_in = 16'h7FFF;
      end else if (tcs < -27'sd32768) begin
         tc_in = 16'h8000;
      end else begin
         tc_in = tcs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         m1_ff   <= m1_in;
         bb2_ff  <= bb2_in;
         v1t3_ff <= m1_ff[33:11];
         m3_ff   <= m3_in;
         tf4_ff  <= tf4_in;
         v1_ff   <= v1_in;
         side_ff <= '{temp_centi: tc_in, fine_temp: tf4_ff, invalid: 1'b0};
         rp_ff[0] <= raw_pressure;
         for (int i = 1; i < STAGES; i++) begin
            rp_ff[i] <= rp_ff[i-1];
         end
      end
   end

   assign out_valid        = vld_ff[STAGES-1];
   assign out_v1           = v1_ff;
   assign out_raw_pressure = rp_ff[STAGES-1];
   assign out_side         = side_ff;

endmodule

`default_nettype wire

// ===== design/bpc_poly.sv =====
// Pressure polynomial ahead of the divide: six stages to dividend and divisor magnitudes.
`default_nettype none

module bpc_poly (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire bpc_pkg::cal_type               cal,
   input  wire logic                           in_valid,
   input  wire logic signed [31:0]             v1,
   input  wire logic [19:0]                    raw_pressure,
   input  wire bpc_pkg::side_type              in_side,
   output logic                                out_valid,
   output logic [bpc_pkg::NUM_W-1:0]           num_mag,
   output logic [bpc_pkg::DEN_W-1:0]           den_mag,
   output logic                                neg,
   output bpc_pkg::side_type                   out_side
);

   localparam int STAGES = 6;

   logic [STAGES-1:0]  vld_ff;
   bpc_pkg::side_type  side_ff [STAGES];
   logic [19:0]        rp_ff [3];

   logic signed [15:0] p2, p3, p4, p5, p6;
   logic signed [16:0] p1s;

   logic signed [63:0] vv1_ff;
   logic signed [47:0] v1p5_ff, v1p2_ff, v1p5_2_ff, v1p2_2_ff;
   logic signed [46:0] vv47;
   logic signed [62:0] vvp6_in, vvp6_ff, vvp3_in, vvp3_ff;
   logic [63:0]        v2_in, v2_ff;
   logic [63:0]        x_in, x_ff;
   logic [20:0]        pw;
   logic signed [27:0] xh;
   logic [43:0]        xl_p1_ff;
   logic signed [44:0] xh_p1_in, xh_p1_ff;
   logic [63:0]        num0_ff, num5_ff;
   logic [63:0]        dsum;
   logic [bpc_pkg::DEN_W-1:0] den5_ff;
   logic [bpc_pkg::NUM_W-1:0] num_mag_ff;
   logic [bpc_pkg::DEN_W-1:0] den_mag_ff;
   logic               neg_ff;
   bpc_pkg::side_type  side_in;

   assign p1s = $signed({1'b0, cal.p1});
   assign p2  = cal.p2;
   assign p3  = cal.p3;
   assign p4  = cal.p4;
   assign p5  = cal.p5;
   assign p6  = cal.p6;

   // v1 is well under 2^23, so its square fits 47 bits
   assign vv47    = vv1_ff[46:0];
   assign vvp6_in = 63'(vv47) * 63'(p6);
   assign vvp3_in = 63'(vv47) * 63'(p3);

   assign v2_in = {vvp6_ff[62], vvp6_ff} + {v1p5_2_ff[46:0], 17'b0}
                + {{13{p4[15]}}, p4, 35'b0};
   assign x_in  = 64'h0000_8000_0000_0000 + {{9{vvp3_ff[62]}}, vvp3_ff[62:8]}
                + {{4{v1p2_2_ff[47]}}, v1p2_2_ff, 12'b0};

   assign pw       = 21'd1048576 - {1'b0, rp_ff[2]};
   assign xh       = x_ff[55:28];
   assign xh_p1_in = 45'(xh) * 45'(p1s);

   // low 64 bits of x * p1, split at bit 28
   assign dsum = {xh_p1_ff[35:0], 28'b0} + {20'b0, xl_p1_ff};

   always_comb begin
      side_in         = side_ff[4];
      side_in.invalid = (den5_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vv1_ff    <= 64'(v1) * 64'(v1);
         v1p5_ff   <= 48'(v1) * 48'(p5);
         v1p2_ff   <= 48'(v1) * 48'(p2);
         vvp6_ff   <= vvp6_in;
         vvp3_ff   <= vvp3_in;
         v1p5_2_ff <= v1p5_ff;
         v1p2_2_ff <= v1p2_ff;
         v2_ff     <= v2_in;
         x_ff      <= x_in;
         num0_ff   <= {12'b0, pw, 31'b0} - v2_ff;
         xl_p1_ff  <= 44'(x_ff[27:0]) * 44'(cal.p1);
         xh_p1_ff  <= xh_p1_in;
         num5_ff   <= num0_ff * 64'd3125;
         den5_ff   <= dsum[63:33];
         neg_ff     <= num5_ff[63] ^ den5_ff[bpc_pkg::DEN_W-1];
         num_mag_ff <= num5_ff[63] ? (64'd0 - num5_ff) : num5_ff;
         den_mag_ff <= den5_ff[bpc_pkg::DEN_W-1] ? (31'd0 - den5_ff) : den5_ff;
         rp_ff[0] <= raw_pressure;
         rp_ff[1] <= rp_ff[0];
         rp_ff[2] <= rp_ff[1];
         side_ff[0] <= in_side;
         for (int i = 1; i < STAGES - 1; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         side_ff[STAGES-1] <= side_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign num_mag   = num_mag_ff;
   assign den_mag   = den_mag_ff;
   assign neg       = neg_ff;
   assign out_side  = side_ff[STAGES-1];

endmodule

`default_nettype wire

// ===== design/bpc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
`default_nettype none

module bpc_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic [bpc_pkg::NUM_W-1:0]      num_mag,
   input  wire logic [bpc_pkg::DEN_W-1:0]      den_mag,
   input  wire logic                           in_neg,
   input  wire bpc_pkg::side_type              in_side,
   output logic                                out_valid,
   output logic [bpc_pkg::NUM_W-1:0]           quo,
   output logic                                out_neg,
   output bpc_pkg::side_type                   out_side
);

   localparam int N  = bpc_pkg::DIV_STAGES;
   localparam int NW = bpc_pkg::NUM_W;
   localparam int DW = bpc_pkg::DEN_W;

   logic              vld_ff  [N];
   logic [DW-1:0]     rem_ff  [N];
   logic [NW-1:0]     n_ff    [N];
   logic [DW-1:0]     d_ff    [N];
   logic              neg_ff  [N];
   bpc_pkg::side_type side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic              v_src;
      logic [DW-1:0]     rem_src;
      logic [NW-1:0]     n_src;
      logic [DW-1:0]     d_src;
      logic              neg_src;
      bpc_pkg::side_type side_src;
      logic [DW:0]       trial;
      logic [DW:0]       diff;
      logic              ge;
      logic [DW-1:0]     rem_in;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign n_src    = num_mag;
         assign d_src    = den_mag;
         assign neg_src  = in_neg;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign n_src    = n_ff[k-1];
         assign d_src    = d_ff[k-1];
         assign neg_src  = neg_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign trial  = {rem_src, n_src[NW-1]};
      assign diff   = trial - {1'b0, d_src};
      assign ge     = (trial >= {1'b0, d_src});
      assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            n_ff[k]    <= {n_src[NW-2:0], ge};
            d_ff[k]    <= d_src;
            neg_ff[k]  <= neg_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign quo       = n_ff[N-1];
   assign out_neg   = neg_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

`default_nettype wire

// ===== design/bpc_post.sv =====
// Pressure correction after the divide, clamping and result register: seven stages.
`default_nettype none

module bpc_post (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire bpc_pkg::cal_type               cal,
   input  wire logic                           in_valid,
   input  wire logic [bpc_pkg::NUM_W-1:0]      quo,
   input  wire logic                           in_neg,
   input  wire bpc_pkg::side_type              in_side,
   output logic                                out_valid,
   output logic [15:0]                         temperature_centi,
   output logic [31:0]                         fine_temperature,
   output logic [31:0]                         pressure_q24_8,
   output logic                                pressure_invalid
);

   localparam int STAGES = 7;

   logic [STAGES-1:0] vld_ff;
   bpc_pkg::side_type side_ff [STAGES];

   logic [63:0] p8e, p9e;
   logic [63:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic [63:0] q;
   logic [63:0] sq_ll_ff, sq3_ff;
   logic [31:0] sq_lh_ff;
   logic [63:0] b_ll_ff;
   logic [31:0] b_lh_ff, b_hl_ff;
   logic [63:0] bsum;
   logic [63:0] bt3_ff, bt4_ff, bt5_ff;
   logic [63:0] a_ll_ff;
   logic [31:0] a_lh_ff, a_hl_ff;
   logic [63:0] asum5_ff;
   logic [63:0] s6_ff;
   logic [63:0] r;
   logic [31:0] press_in, press_ff;

   assign p8e = {{48{cal.p8[15]}}, cal.p8};
   assign p9e = {{48{cal.p9[15]}}, cal.p9};

   assign q    = {{13{p1_ff[63]}}, p1_ff[63:13]};
   assign bsum = b_ll_ff + {b_lh_ff + b_hl_ff, 32'b0};
   assign r    = {{8{s6_ff[63]}}, s6_ff[63:8]} + {{44{cal.p7[15]}}, cal.p7, 4'b0};

   always_comb begin
      if (side_ff[5].invalid || r[63]) begin
         press_in = '0;
      end else if (|r[62:32]) begin
         press_in = '1;
      end else begin
         press_in = r[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // 64-bit products mod 2^64 from 32x32 partial products
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= in_neg ? (64'd0 - quo) : quo;
         sq_ll_ff <= 64'(q[31:0]) * 64'(q[31:0]);
         sq_lh_ff <= q[31:0] * q[63:32];
         b_ll_ff  <= 64'(p1_ff[31:0]) * 64'(p8e[31:0]);
         b_lh_ff  <= p1_ff[31:0] * p8e[63:32];
         b_hl_ff  <= p1_ff[63:32] * p8e[31:0];
         p2_ff    <= p1_ff;
         sq3_ff   <= sq_ll_ff + {sq_lh_ff[30:0], 1'b0, 32'b0};
         bt3_ff   <= {{19{bsum[63]}}, bsum[63:19]};
         p3_ff    <= p2_ff;
         a_ll_ff  <= 64'(sq3_ff[31:0]) * 64'(p9e[31:0]);
         a_lh_ff  <= sq3_ff[31:0] * p9e[63:32];
         a_hl_ff  <= sq3_ff[63:32] * p9e[31:0];
         bt4_ff   <= bt3_ff;
         p4_ff    <= p3_ff;
         asum5_ff <= a_ll_ff + {a_lh_ff + a_hl_ff, 32'b0};
         bt5_ff   <= bt4_ff;
         p5_ff    <= p4_ff;
         s6_ff    <= p5_ff + {{25{asum5_ff[63]}}, asum5_ff[63:25]} + bt5_ff;
         press_ff <= press_in;
         side_ff[0] <= in_side;
         for (int i = 1; i < STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid         = vld_ff[STAGES-1];
   assign temperature_centi = side_ff[STAGES-1].temp_centi;
   assign fine_temperature  = side_ff[STAGES-1].fine_temp;
   assign pressure_q24_8    = press_ff;
   assign pressure_invalid  = side_ff[STAGES-1].invalid;

endmodule

`default_nettype wire

// ===== design/barometric_temp_pressure_compensation_core.sv =====
// Barometric sensor compensation core: temperature then pressure polynomial.
//
// req channel carries one pair of raw 20-bit temperature and pressure readings
// per request; rsp channel returns compensated temperature (0.01 degC), the
// fine temperature term and pressure in pascal Q24.8, with rsp_tuser set when
// the pressure divisor was zero (pressure then reads 0).
// Calibration words are written through csr_we/csr_addr/csr_wdata; the user must
// write them only while the core is idle, which the core itself does not enforce.
// They are read in place by the temperature, polynomial and correction stages.
// One request per cycle is taken while rsp_tready does not stall the pipeline.
// The pipeline has 82 register stages: 5 temperature stages, 6 polynomial
// stages, 64 divider stages (one quotient bit each) and 7 correction stages.
// The whole pipeline advances together; when rsp_tready is low with a result
// waiting, it holds, and one more request is caught in an input skid register
// before req_tready drops. Reset (synchronous) clears all valid bits, the skid
// valid flag and the calibration words.
`default_nettype none

module barometric_temp_pressure_compensation_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // temperature_centi[15:0], fine_temperature[47:16],
                                         // pressure_q24_8[79:48]
   output logic             rsp_tuser,   // pressure_invalid
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);

   logic [47:0] cal_t_ff;
   logic [63:0] cal_pl_ff;
   logic [63:0] cal_pm_ff;
   logic [15:0] cal_ph_ff;
   bpc_pkg::cal_type cal;

   logic        en;
   logic        skid_valid_ff;
   logic [39:0] skid_data_ff;
   logic        pipe_valid;
   logic [39:0] pipe_data;

   logic              t_valid;
   logic signed [31:0] t_v1;
   logic [19:0]       t_rp;
   bpc_pkg::side_type t_side;

   logic                           y_valid;
   logic [bpc_pkg::NUM_W-1:0]      y_num;
   logic [bpc_pkg::DEN_W-1:0]      y_den;
   logic                           y_neg;
   bpc_pkg::side_type              y_side;

   logic                           d_valid;
   logic [bpc_pkg::NUM_W-1:0]      d_quo;
   logic                           d_neg;
   bpc_pkg::side_type              d_side;

   logic [15:0] o_temp;
   logic [31:0] o_fine;
   logic [31:0] o_press;
   logic        o_inv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff  <= '0;
         cal_pl_ff <= '0;
         cal_pm_ff <= '0;
         cal_ph_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            bpc_pkg::CSR_CAL_TEMP:   cal_t_ff  <= csr_wdata[47:0];
            bpc_pkg::CSR_CAL_P_LOW:  cal_pl_ff <= csr_wdata;
            bpc_pkg::CSR_CAL_P_MID:  cal_pm_ff <= csr_wdata;
            bpc_pkg::CSR_CAL_P_HIGH: cal_ph_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cal = '{t1: cal_t_ff[15:0],  t2: cal_t_ff[31:16], t3: cal_t_ff[47:32],
                  p1: cal_pl_ff[15:0], p2: cal_pl_ff[31:16], p3: cal_pl_ff[47:32],
                  p4: cal_pl_ff[63:48],
                  p5: cal_pm_ff[15:0], p6: cal_pm_ff[31:16], p7: cal_pm_ff[47:32],
                  p8: cal_pm_ff[63:48],
                  p9: cal_ph_ff};

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign pipe_valid = skid_valid_ff || req_tvalid;
   assign pipe_data  = skid_valid_ff ? skid_data_ff : req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_tvalid && req_tready) begin
         skid_data_ff <= req_tdata;
      end
   end

   bpc_temp u_temp (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .cal              (cal),
      .in_valid         (pipe_valid),
      .raw_temperature  (pipe_data[19:0]),
      .raw_pressure     (pipe_data[39:20]),
      .out_valid        (t_valid),
      .out_v1           (t_v1),
      .out_raw_pressure (t_rp),
      .out_side         (t_side)
   );

   bpc_poly u_poly (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cal          (cal),
      .in_valid     (t_valid),
      .v1           (t_v1),
      .raw_pressure (t_rp),
      .in_side      (t_side),
      .out_valid    (y_valid),
      .num_mag      (y_num),
      .den_mag      (y_den),
      .neg          (y_neg),
      .out_side     (y_side)
   );

   bpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (y_valid),
      .num_mag   (y_num),
      .den_mag   (y_den),
      .in_neg    (y_neg),
      .in_side   (y_side),
      .out_valid (d_valid),
      .quo       (d_quo),
      .out_neg   (d_neg),
      .out_side  (d_side)
   );

   bpc_post u_post (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .cal               (cal),
      .in_valid          (d_valid),
      .quo               (d_quo),
      .in_neg            (d_neg),
      .in_side           (d_side),
      .out_valid         (rsp_tvalid),
      .temperature_centi (o_temp),
      .fine_temperature  (o_fine),
      .pressure_q24_8    (o_press),
      .pressure_invalid  (o_inv)
   );

   assign rsp_tdata = {o_press, o_fine, o_temp};
   assign rsp_tuser = o_inv;

endmodule

`default_nettype wire
